/* rtl/als_lux_and_status_handler_core_macros.svh */
// assertion macros shared by the light/status handler rtl
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef ALS_LUX_AND_STATUS_HANDLER_CORE_MACROS_SVH
`define ALS_LUX_AND_STATUS_HANDLER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ALS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ALS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ALS_ASSERT_IMP(lbl, ante, cons, msg)

`define ALS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/als_pkg.sv */
// types, constants and microprogram for the light/status handler
// no dependencies
`default_nettype none

package als_pkg;

    localparam int PC_W = 4;

    // coefficients, Q2.14
    localparam logic [23:0] COEF_B = 24'd30507;
    localparam logic [23:0] COEF_C = 24'd12222;
    localparam logic [23:0] COEF_D = 24'd21152;

    localparam logic [15:0] IRF_MAX = 16'd32768;

    // configuration register indexes
    localparam logic [1:0] REG_LUX_PER_COUNT = 2'd0;
    localparam logic [1:0] REG_ALS_TIME      = 2'd1;
    localparam logic [1:0] REG_ALS_ENABLE    = 2'd2;
    localparam logic [1:0] REG_PROX_ENABLE   = 2'd3;

    // microprogram step addresses
    localparam logic [PC_W-1:0] STEP_WAIT     = 4'd0;
    localparam logic [PC_W-1:0] STEP_LATCH    = 4'd1;
    localparam logic [PC_W-1:0] STEP_MUL_B    = 4'd2;
    localparam logic [PC_W-1:0] STEP_IAC1     = 4'd3;
    localparam logic [PC_W-1:0] STEP_MUL_C    = 4'd4;
    localparam logic [PC_W-1:0] STEP_MUL_D    = 4'd5;
    localparam logic [PC_W-1:0] STEP_IAC2     = 4'd6;
    localparam logic [PC_W-1:0] STEP_MUL_LUX  = 4'd7;
    localparam logic [PC_W-1:0] STEP_LUX      = 4'd8;
    localparam logic [PC_W-1:0] STEP_DIV      = 4'd9;
    localparam logic [PC_W-1:0] STEP_IRF      = 4'd10;
    localparam logic [PC_W-1:0] STEP_EMIT     = 4'd11;
    localparam logic [PC_W-1:0] STEP_LAST     = STEP_EMIT;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_IR_B,
        MUL_FULL_C,
        MUL_IR_D,
        MUL_IAC_LPC
    } mul_sel_t;

    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_ACCEPT,
        ALU_LATCH,
        ALU_IAC1,
        ALU_SAVE,
        ALU_IAC2,
        ALU_DIV_INIT,
        ALU_LUX,
        ALU_DIV_STEP,
        ALU_IRF,
        ALU_EMIT
    } alu_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_SKIP_LIGHT,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        mul_sel_t        mul;
        alu_op_t         alu;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic no_input;
        logic skip_light;
        logic div_more;
        logic out_busy;
    } seq_status_t;

    function automatic ctrl_t prog_word(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{mul: MUL_NONE, alu: ALU_NOP, cond: COND_NEVER, target: STEP_WAIT};
        unique case (pc)
            STEP_WAIT:    w = '{MUL_NONE,    ALU_ACCEPT,   COND_NO_INPUT,   STEP_WAIT};
            STEP_LATCH:   w = '{MUL_NONE,    ALU_LATCH,    COND_SKIP_LIGHT, STEP_EMIT};
            STEP_MUL_B:   w = '{MUL_IR_B,    ALU_NOP,      COND_NEVER,      STEP_WAIT};
            STEP_IAC1:    w = '{MUL_NONE,    ALU_IAC1,     COND_NEVER,      STEP_WAIT};
            STEP_MUL_C:   w = '{MUL_FULL_C,  ALU_NOP,      COND_NEVER,      STEP_WAIT};
            STEP_MUL_D:   w = '{MUL_IR_D,    ALU_SAVE,     COND_NEVER,      STEP_WAIT};
            STEP_IAC2:    w = '{MUL_NONE,    ALU_IAC2,     COND_NEVER,      STEP_WAIT};
            STEP_MUL_LUX: w = '{MUL_IAC_LPC, ALU_DIV_INIT, COND_NEVER,      STEP_WAIT};
            STEP_LUX:     w = '{MUL_NONE,    ALU_LUX,      COND_NEVER,      STEP_WAIT};
            STEP_DIV:     w = '{MUL_NONE,    ALU_DIV_STEP, COND_DIV_MORE,   STEP_DIV};
            STEP_IRF:     w = '{MUL_NONE,    ALU_IRF,      COND_NEVER,      STEP_WAIT};
            STEP_EMIT:    w = '{MUL_NONE,    ALU_EMIT,     COND_OUT_BUSY,   STEP_EMIT};
            default:      w = '{MUL_NONE,    ALU_NOP,      COND_ALWAYS,     STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/als_lux_and_status_handler_core.sv */
// top level of the light/status handler: sequencer plus datapath
// depends on als_pkg, als_seq and als_dp
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   status flags, full, ir and prox counts
//   m_        out        m_valid / m_ready   held lux, ir factor, flags, counts, clear action
//   cfg_      in         cfg_wr_en           cfg_addr, cfg_wdata, no wait
//
// a beat with als work runs from accept to the result beat through ten program steps, the
// emit step among them, and 16 passes of the serial divider that forms the ir factor; the
// result is then offered from the output register
// a beat without als work (flags missing, disabled or saturated) skips from latch to emit
// the next beat is taken once the result sits in the output register
// a stalled output holds the program at its emit step; reset returns it to the wait step
`default_nettype none

module als_lux_and_status_handler_core
    import als_pkg::*;
#(
    parameter int LUX_FRAC_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_als_interrupt,
    input  wire logic        s_als_valid,
    input  wire logic        s_prox_interrupt,
    input  wire logic        s_prox_valid,
    input  wire logic [15:0] s_full_count,
    input  wire logic [15:0] s_ir_count,
    input  wire logic [15:0] s_prox_count,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_lux,
    output logic [15:0]      m_ir_factor,
    output logic             m_saturated,
    output logic             m_ripple_saturated,
    output logic [15:0]      m_full_value,
    output logic [15:0]      m_ir_value,
    output logic [15:0]      m_prox_value,
    output logic [1:0]       m_clear_action
);

    ctrl_t       ctrl;
    seq_status_t status;

    als_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    als_dp #(
        .LUX_FRAC_BITS (LUX_FRAC_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .ctrl               (ctrl),
        .status             (status),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_als_interrupt    (s_als_interrupt),
        .s_als_valid        (s_als_valid),
        .s_prox_interrupt   (s_prox_interrupt),
        .s_prox_valid       (s_prox_valid),
        .s_full_count       (s_full_count),
        .s_ir_count         (s_ir_count),
        .s_prox_count       (s_prox_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_lux              (m_lux),
        .m_ir_factor        (m_ir_factor),
        .m_saturated        (m_saturated),
        .m_ripple_saturated (m_ripple_saturated),
        .m_full_value       (m_full_value),
        .m_ir_value         (m_ir_value),
        .m_prox_value       (m_prox_value),
        .m_clear_action     (m_clear_action)
    );

endmodule

`default_nettype wire

/* rtl/als_seq.sv */
// microprogram sequencer: step counter, control store and jump logic
// depends on als_pkg and the assertion macro header
`default_nettype none
`include "als_lux_and_status_handler_core_macros.svh"

module als_seq
    import als_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire seq_status_t status,
    output ctrl_t            ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign ctrl = prog_word(pc_reg);

    always_comb begin
        unique case (ctrl.cond)
            COND_NEVER:      take = 1'b0;
            COND_ALWAYS:     take = 1'b1;
            COND_NO_INPUT:   take = status.no_input;
            COND_SKIP_LIGHT: take = status.skip_light;
            COND_DIV_MORE:   take = status.div_more;
            COND_OUT_BUSY:   take = status.out_busy;
            default:         take = 1'b1;
        endcase
        if (take) begin
            pc_next = ctrl.target;
        end else if (pc_reg == STEP_LAST) begin
            pc_next = STEP_WAIT;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    `ALS_ASSERT_IMP(a_pc_range, 1'b1, pc_reg <= STEP_LAST, "step counter outside program")
    `ALS_ASSERT_NXT(a_accept_step, pc_reg == STEP_WAIT && !status.no_input, pc_reg == STEP_LATCH, "accepted beat not followed by latch step")
    `ALS_ASSERT_NXT(a_emit_hold, pc_reg == STEP_EMIT && status.out_busy, pc_reg == STEP_EMIT, "emit step left while output slot full")
    `ALS_ASSERT_NXT(a_div_loop, pc_reg == STEP_DIV && status.div_more, pc_reg == STEP_DIV, "divider loop exited early")

endmodule

`default_nettype wire

/* rtl/als_dp.sv */
// datapath: config registers, held state, shared multiplier, serial divider, output slot
// depends on als_pkg
`default_nettype none

module als_dp
    import als_pkg::*;
#(
    parameter int LUX_FRAC_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ctrl_t       ctrl,
    output seq_status_t      status,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_als_interrupt,
    input  wire logic        s_als_valid,
    input  wire logic        s_prox_interrupt,
    input  wire logic        s_prox_valid,
    input  wire logic [15:0] s_full_count,
    input  wire logic [15:0] s_ir_count,
    input  wire logic [15:0] s_prox_count,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_lux,
    output logic [15:0]      m_ir_factor,
    output logic             m_saturated,
    output logic             m_ripple_saturated,
    output logic [15:0]      m_full_value,
    output logic [15:0]      m_ir_value,
    output logic [15:0]      m_prox_value,
    output logic [1:0]       m_clear_action
);

    localparam int LUX_SHIFT = 30 - LUX_FRAC_BITS;

    // configuration
    logic [23:0] lpc_reg;
    logic [7:0]  atime_reg;
    logic        als_en_reg;
    logic        prox_en_reg;

    // captured beat
    logic        als_go_reg;
    logic        prox_go_reg;
    logic [15:0] full_reg;
    logic [15:0] ir_reg;
    logic [15:0] prox_reg;

    // held state
    logic [15:0] held_full_reg;
    logic [15:0] held_ir_reg;
    logic [31:0] held_lux_reg;
    logic [15:0] held_irf_reg;
    logic        held_sat_reg;
    logic        held_ripple_reg;
    logic [15:0] held_prox_reg;

    // working registers
    logic [53:0] mul_reg;
    logic [31:0] tmp_reg;
    logic [29:0] iac_reg;
    logic [15:0] rem_reg;
    logic [15:0] dq_reg;
    logic [3:0]  cnt_reg;

    // output slot
    logic        m_valid_reg;
    logic [31:0] m_lux_reg;
    logic [15:0] m_irf_reg;
    logic        m_sat_reg;
    logic        m_ripple_reg;
    logic [15:0] m_full_reg;
    logic [15:0] m_ir_reg;
    logic [15:0] m_prox_reg;
    logic [1:0]  m_action_reg;

    logic [29:0] mul_a;
    logic [23:0] mul_b;
    logic [53:0] mul_p;
    logic [8:0]  time_diff;
    logic [16:0] limit;
    logic [18:0] limit_x3;
    logic [16:0] ripple_lim;
    logic        sat;
    logic        ripple;
    logic signed [32:0] diff1;
    logic signed [32:0] diff2;
    logic [53:0] lux_shifted;
    logic [16:0] trial;
    logic        trial_ge;
    logic [16:0] trial_sub;
    logic        out_busy;
    logic        accept;
    logic        load_out;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (ctrl.alu == ALU_ACCEPT);
    assign out_busy = m_valid_reg && !m_ready;
    assign load_out = (ctrl.alu == ALU_EMIT) && !out_busy;

    // saturation limits from the integration time register
    assign time_diff  = 9'd256 - {1'b0, atime_reg};
    assign limit      = (atime_reg <= 8'd192) ? 17'd65535 : {time_diff[6:0], 10'b0};
    assign limit_x3   = {2'b0, limit} + {1'b0, limit, 1'b0};
    assign ripple_lim = limit_x3[18:2];
    assign sat        = ({1'b0, full_reg} >= limit) || ({1'b0, ir_reg} >= limit);
    assign ripple     = ({1'b0, full_reg} >= ripple_lim) || ({1'b0, ir_reg} >= ripple_lim);

    assign status.no_input   = !s_valid;
    assign status.skip_light = !als_go_reg || sat;
    assign status.div_more   = (cnt_reg != 4'd15);
    assign status.out_busy   = out_busy;

    // shared multiplier operands
    always_comb begin
        unique case (ctrl.mul)
            MUL_IR_B:    begin mul_a = {14'b0, ir_reg};   mul_b = COEF_B;  end
            MUL_FULL_C:  begin mul_a = {14'b0, full_reg}; mul_b = COEF_C;  end
            MUL_IR_D:    begin mul_a = {14'b0, ir_reg};   mul_b = COEF_D;  end
            MUL_IAC_LPC: begin mul_a = iac_reg;           mul_b = lpc_reg; end
            default:     begin mul_a = '0;                mul_b = '0;      end
        endcase
    end
    assign mul_p = {24'b0, mul_a} * {30'b0, mul_b};

    assign diff1 = $signed({3'b0, full_reg, 14'b0}) - $signed({1'b0, mul_reg[31:0]});
    assign diff2 = $signed({1'b0, tmp_reg}) - $signed({1'b0, mul_reg[31:0]});

    assign lux_shifted = mul_reg >> LUX_SHIFT;

    // one restoring divide step: remainder stays below full
    assign trial     = {rem_reg, dq_reg[15]};
    assign trial_ge  = trial >= {1'b0, full_reg};
    assign trial_sub = trial - {1'b0, full_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lpc_reg         <= '0;
            atime_reg       <= 8'd255;
            als_en_reg      <= 1'b1;
            prox_en_reg     <= 1'b1;
            held_full_reg   <= '0;
            held_ir_reg     <= '0;
            held_lux_reg    <= '0;
            held_irf_reg    <= '0;
            held_sat_reg    <= 1'b0;
            held_ripple_reg <= 1'b0;
            held_prox_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_LUX_PER_COUNT: lpc_reg     <= cfg_wdata;
                    REG_ALS_TIME:      atime_reg   <= cfg_wdata[7:0];
                    REG_ALS_ENABLE:    als_en_reg  <= cfg_wdata[0];
                    REG_PROX_ENABLE:   prox_en_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end

            case (ctrl.alu)
                ALU_LATCH: begin
                    if (prox_go_reg) begin
                        held_prox_reg <= prox_reg;
                    end
                    if (als_go_reg) begin
                        held_full_reg <= full_reg;
                        held_ir_reg   <= ir_reg;
                        if (sat) begin
                            held_sat_reg <= 1'b1;
                        end
                    end
                end
                ALU_IAC1: begin
                    held_sat_reg    <= 1'b0;
                    held_ripple_reg <= ripple;
                end
                ALU_LUX: begin
                    held_lux_reg <= (|lux_shifted[53:32]) ? 32'hFFFF_FFFF : lux_shifted[31:0];
                end
                ALU_IRF: begin
                    if (full_reg == 16'd0) begin
                        held_irf_reg <= '0;
                    end else if (dq_reg > IRF_MAX) begin
                        held_irf_reg <= IRF_MAX;
                    end else begin
                        held_irf_reg <= dq_reg;
                    end
                end
                default: ;
            endcase

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload and working registers, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            als_go_reg  <= als_en_reg && s_als_interrupt && s_als_valid;
            prox_go_reg <= prox_en_reg && s_prox_interrupt && s_prox_valid;
            full_reg    <= s_full_count;
            ir_reg      <= s_ir_count;
            prox_reg    <= s_prox_count;
        end

        if (ctrl.mul != MUL_NONE) begin
            mul_reg <= mul_p;
        end

        case (ctrl.alu)
            ALU_IAC1: begin
                iac_reg <= diff1[32] ? 30'd0 : diff1[29:0];
            end
            ALU_SAVE: begin
                tmp_reg <= mul_reg[31:0];
            end
            ALU_IAC2: begin
                if (!diff2[32] && (diff2[29:0] > iac_reg)) begin
                    iac_reg <= diff2[29:0];
                end
            end
            ALU_DIV_INIT: begin
                // dividend is twice iac; top part already below full
                rem_reg <= {1'b0, iac_reg[29:15]};
                dq_reg  <= {iac_reg[14:0], 1'b0};
                cnt_reg <= '0;
            end
            ALU_DIV_STEP: begin
                rem_reg <= trial_ge ? trial_sub[15:0] : trial[15:0];
                dq_reg  <= {dq_reg[14:0], trial_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: ;
        endcase

        if (load_out) begin
            m_lux_reg    <= held_lux_reg;
            m_irf_reg    <= held_irf_reg;
            m_sat_reg    <= held_sat_reg;
            m_ripple_reg <= held_ripple_reg;
            m_full_reg   <= held_full_reg;
            m_ir_reg     <= held_ir_reg;
            m_prox_reg   <= held_prox_reg;
            // bit 1 proximity clear, bit 0 als clear
            m_action_reg <= {prox_en_reg, als_en_reg};
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_lux              = m_lux_reg;
    assign m_ir_factor        = m_irf_reg;
    assign m_saturated        = m_sat_reg;
    assign m_ripple_saturated = m_ripple_reg;
    assign m_full_value       = m_full_reg;
    assign m_ir_value         = m_ir_reg;
    assign m_prox_value       = m_prox_reg;
    assign m_clear_action     = m_action_reg;

endmodule

`default_nettype wire

/* test/als_lux_checker.sv */
// scoreboard for the light/status handler: follows register writes, predicts one reading per
// accepted status beat and compares every result beat field by field
// depends on als_pkg for the register indexes
module als_lux_checker
    import als_pkg::*;
#(
    parameter int LUX_FRAC_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_als_interrupt,
    input  wire logic        s_als_valid,
    input  wire logic        s_prox_interrupt,
    input  wire logic        s_prox_valid,
    input  wire logic [15:0] s_full_count,
    input  wire logic [15:0] s_ir_count,
    input  wire logic [15:0] s_prox_count,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_lux,
    input  wire logic [15:0] m_ir_factor,
    input  wire logic        m_saturated,
    input  wire logic        m_ripple_saturated,
    input  wire logic [15:0] m_full_value,
    input  wire logic [15:0] m_ir_value,
    input  wire logic [15:0] m_prox_value,
    input  wire logic [1:0]  m_clear_action,
    output int               n_fail,
    output int               n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Q2.14 weights of the two illuminance formulas
    localparam longint W_ONE  = 16384;
    localparam longint W_IR_A = 30507;
    localparam longint W_FULL = 12222;
    localparam longint W_IR_B = 21152;

    typedef enum logic [1:0] {
        CLR_NONE = 2'd0,
        CLR_ALS  = 2'd1,
        CLR_PROX = 2'd2,
        CLR_BOTH = 2'd3
    } clear_t;

    typedef struct packed {
        logic [31:0] lux;
        logic [15:0] ir_factor;
        logic        saturated;
        logic        ripple;
        logic [15:0] full;
        logic [15:0] ir;
        logic [15:0] prox;
        clear_t      clear;
    } reading_t;

    logic [23:0] lux_scale;
    logic [7:0]  integ_time;
    logic        als_on;
    logic        prox_on;

    logic [15:0] keep_full;
    logic [15:0] keep_ir;
    logic [15:0] keep_prox;
    logic [31:0] keep_lux;
    logic [15:0] keep_irf;
    logic        keep_sat;
    logic        keep_ripple;

    reading_t readings_due[$];

    initial begin
        n_fail = 0;
        n_pending = 0;
    end

    function automatic reading_t predict_reading(input logic ai, input logic av,
                                                 input logic pi, input logic pv,
                                                 input logic [15:0] full, input logic [15:0] ir,
                                                 input logic [15:0] prox);
        longint lim;
        longint rip;
        longint iac;
        longint alt;
        longint unsigned lux_wide;
        reading_t r;
        if (als_on && ai && av) begin
            keep_full = full;
            keep_ir = ir;
            lim = (integ_time <= 8'd192) ? 65535 : 1024 * (256 - longint'(integ_time));
            rip = (lim * 3) >> 2;
            if (longint'(full) >= lim || longint'(ir) >= lim) begin
                // lux, ir factor and ripple keep their old values
                keep_sat = 1'b1;
            end else begin
                keep_sat = 1'b0;
                keep_ripple = (longint'(full) >= rip || longint'(ir) >= rip);
                iac = longint'(full) * W_ONE - longint'(ir) * W_IR_A;
                alt = longint'(full) * W_FULL - longint'(ir) * W_IR_B;
                if (alt > iac) iac = alt;
                if (iac < 0) iac = 0;
                lux_wide = ($unsigned(iac) * lux_scale) >> (30 - LUX_FRAC_BITS);
                keep_lux = (lux_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lux_wide[31:0];
                keep_irf = (full == 16'd0) ? 16'd0 : 16'((iac * 2) / longint'(full));
            end
        end
        if (prox_on && pi && pv) keep_prox = prox;

        r.lux = keep_lux;
        r.ir_factor = keep_irf;
        r.saturated = keep_sat;
        r.ripple = keep_ripple;
        r.full = keep_full;
        r.ir = keep_ir;
        r.prox = keep_prox;
        case ({als_on, prox_on})
            2'b11:   r.clear = CLR_BOTH;
            2'b10:   r.clear = CLR_ALS;
            2'b01:   r.clear = CLR_PROX;
            default: r.clear = CLR_NONE;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        n_fail++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", what, got, want));
    endtask

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            lux_scale = 24'd0;
            integ_time = 8'd255;
            als_on = 1'b1;
            prox_on = 1'b1;
            keep_full = '0;
            keep_ir = '0;
            keep_prox = '0;
            keep_lux = '0;
            keep_irf = '0;
            keep_sat = 1'b0;
            keep_ripple = 1'b0;
            readings_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (readings_due.size() == 0) begin
                    report_mismatch("result beat with no reading expected");
                end else begin
                    want = readings_due.pop_front();
                    check_field("lux", m_lux, want.lux);
                    check_field("ir_factor", m_ir_factor, want.ir_factor);
                    check_field("saturated", m_saturated, want.saturated);
                    check_field("ripple_saturated", m_ripple_saturated, want.ripple);
                    check_field("full_value", m_full_value, want.full);
                    check_field("ir_value", m_ir_value, want.ir);
                    check_field("prox_value", m_prox_value, want.prox);
                    check_field("clear_action", m_clear_action, want.clear);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_LUX_PER_COUNT: lux_scale = cfg_wdata;
                    REG_ALS_TIME:      integ_time = cfg_wdata[7:0];
                    REG_ALS_ENABLE:    als_on = cfg_wdata[0];
                    REG_PROX_ENABLE:   prox_on = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                readings_due.push_back(predict_reading(s_als_interrupt, s_als_valid,
                                                       s_prox_interrupt, s_prox_valid,
                                                       s_full_count, s_ir_count,
                                                       s_prox_count));
        end
        n_pending = readings_due.size();
    end

endmodule

/* test/tb.sv */
// top of the light/status handler testbench: clock, reset, register writes, status beats
// with bursty timing and a stalling receiver; checking lives in als_lux_checker
// depends on als_pkg, als_lux_checker and the handler rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import als_pkg::*;

    localparam int FRAC_BITS   = 8;
    localparam int QUIET_LIMIT = 1000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_BEATS = 135;

    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_RUNS
    } rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = REG_LUX_PER_COUNT;
    logic [23:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_als_interrupt = 1'b0;
    logic        s_als_valid = 1'b0;
    logic        s_prox_interrupt = 1'b0;
    logic        s_prox_valid = 1'b0;
    logic [15:0] s_full_count = '0;
    logic [15:0] s_ir_count = '0;
    logic [15:0] s_prox_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_lux;
    logic [15:0] m_ir_factor;
    logic        m_saturated;
    logic        m_ripple_saturated;
    logic [15:0] m_full_value;
    logic [15:0] m_ir_value;
    logic [15:0] m_prox_value;
    logic [1:0]  m_clear_action;

    int n_fail;
    int n_pending;
    int quiet_cycles = 0;
    int burst_left = 0;
    int count_limit = 1024;
    rx_mode_t rx_mode = RX_OPEN;
    int rx_mode_left = 0;
    int rx_hold_left = 0;

    als_lux_and_status_handler_core #(
        .LUX_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_als_interrupt    (s_als_interrupt),
        .s_als_valid        (s_als_valid),
        .s_prox_interrupt   (s_prox_interrupt),
        .s_prox_valid       (s_prox_valid),
        .s_full_count       (s_full_count),
        .s_ir_count         (s_ir_count),
        .s_prox_count       (s_prox_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_lux              (m_lux),
        .m_ir_factor        (m_ir_factor),
        .m_saturated        (m_saturated),
        .m_ripple_saturated (m_ripple_saturated),
        .m_full_value       (m_full_value),
        .m_ir_value         (m_ir_value),
        .m_prox_value       (m_prox_value),
        .m_clear_action     (m_clear_action)
    );

    als_lux_checker #(
        .LUX_FRAC_BITS(FRAC_BITS)
    ) u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_als_interrupt    (s_als_interrupt),
        .s_als_valid        (s_als_valid),
        .s_prox_interrupt   (s_prox_interrupt),
        .s_prox_valid       (s_prox_valid),
        .s_full_count       (s_full_count),
        .s_ir_count         (s_ir_count),
        .s_prox_count       (s_prox_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_lux              (m_lux),
        .m_ir_factor        (m_ir_factor),
        .m_saturated        (m_saturated),
        .m_ripple_saturated (m_ripple_saturated),
        .m_full_value       (m_full_value),
        .m_ir_value         (m_ir_value),
        .m_prox_value       (m_prox_value),
        .m_clear_action     (m_clear_action),
        .n_fail             (n_fail),
        .n_pending          (n_pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver back-pressure, switching between a few stall patterns
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(50, 400);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (rx_hold_left == 0) begin
                    m_ready <= !m_ready;
                    rx_hold_left = $urandom_range(1, 30);
                end else begin
                    rx_hold_left--;
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // registers only change once every outstanding reading has come back
    task automatic set_config(input logic [23:0] scale, input logic [7:0] itime,
                              input logic als_en, input logic prox_en);
        s_valid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_LUX_PER_COUNT;
        cfg_wdata <= scale;
        @(negedge aclk);
        cfg_addr <= REG_ALS_TIME;
        cfg_wdata <= {16'd0, itime};
        @(negedge aclk);
        cfg_addr <= REG_ALS_ENABLE;
        cfg_wdata <= {23'd0, als_en};
        @(negedge aclk);
        cfg_addr <= REG_PROX_ENABLE;
        cfg_wdata <= {23'd0, prox_en};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        count_limit = (itime <= 8'd192) ? 65535 : 1024 * (256 - int'(itime));
    endtask

    task automatic send_status(input logic ai, input logic av, input logic pi, input logic pv,
                               input logic [15:0] full, input logic [15:0] ir,
                               input logic [15:0] prox);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_als_interrupt <= ai;
        s_als_valid <= av;
        s_prox_interrupt <= pi;
        s_prox_valid <= pv;
        s_full_count <= full;
        s_ir_count <= ir;
        s_prox_count <= prox;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // counts clustered round zero, full scale, the saturation limit and the ripple point
    function automatic logic [15:0] pick_count(input int lim);
        int v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = 65535;
            2:       v = lim - 1 + int'($urandom_range(0, 2));
            3:       v = ((lim * 3) >> 2) - 1 + int'($urandom_range(0, 2));
            4, 5:    v = $urandom_range(0, 1023);
            6:       v = $urandom_range(0, lim - 1);
            default: v = $urandom_range(0, 65535);
        endcase
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    task automatic send_random_status();
        logic [3:0]  flags;
        logic [15:0] full;
        int          ir;
        flags = 4'($urandom_range(0, 15));
        full = pick_count(count_limit);
        if ($urandom_range(0, 3) == 0) begin
            ir = pick_count(count_limit);
        end else begin
            // ir at most half of full keeps the light term positive
            ir = (int'(full) * int'($urandom_range(0, 128))) >> 8;
        end
        // mostly complete flag pairs, with a noise beat now and then
        if ($urandom_range(0, 7) != 0) begin
            if ($urandom_range(0, 3) != 0) flags[3:2] = 2'b11;
            if ($urandom_range(0, 3) != 0) flags[1:0] = 2'b11;
        end
        send_status(flags[3], flags[2], flags[1], flags[0], full, ir[15:0],
                    16'($urandom_range(0, 65535)));
    endtask

    initial begin
        logic [23:0] scale;
        logic [7:0]  itime;
        logic        als_en;
        logic        prox_en;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        set_config(24'h010000, 8'd192, 1'b1, 1'b1);
        send_status(1'b0, 1'b0, 1'b0, 1'b0, 16'd1234, 16'd321, 16'd777);
        send_status(1'b1, 1'b0, 1'b0, 1'b0, 16'd1000, 16'd100, 16'd1);
        send_status(1'b0, 1'b1, 1'b0, 1'b0, 16'd1000, 16'd100, 16'd2);
        // zero full count
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd1000, 16'd0, 16'd0);
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd1000, 16'd400, 16'd0);
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd1000, 16'd530, 16'd0);
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd1000, 16'd900, 16'd0);
        // saturated counts with lux held, then both sides of the ripple point
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd65535, 16'd100, 16'd0);
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd100, 16'd65535, 16'd0);
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd49151, 16'd0, 16'd0);
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd49150, 16'd0, 16'd0);
        send_status(1'b0, 1'b0, 1'b1, 1'b0, 16'd5, 16'd5, 16'd4321);
        send_status(1'b0, 1'b0, 1'b0, 1'b1, 16'd5, 16'd5, 16'd4322);
        send_status(1'b0, 1'b0, 1'b1, 1'b1, 16'd5, 16'd5, 16'd65535);
        send_status(1'b0, 1'b0, 1'b1, 1'b1, 16'd5, 16'd5, 16'd0);
        send_status(1'b1, 1'b1, 1'b1, 1'b1, 16'd65534, 16'd65534, 16'hA5A5);

        // shortest integration time: limit 1024
        set_config(24'hFFFFFF, 8'd255, 1'b1, 1'b1);
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd1023, 16'd0, 16'd0);
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd1024, 16'd0, 16'd0);
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd768, 16'd10, 16'd0);

        set_config(24'hFFFFFF, 8'd0, 1'b1, 1'b1);
        send_status(1'b1, 1'b1, 1'b0, 1'b0, 16'd65534, 16'd0, 16'd0);

        // enables off: held values stay, clear action follows the enables
        set_config(24'h010000, 8'd0, 1'b0, 1'b1);
        send_status(1'b1, 1'b1, 1'b1, 1'b1, 16'd300, 16'd20, 16'd300);
        set_config(24'h010000, 8'd0, 1'b1, 1'b0);
        send_status(1'b1, 1'b1, 1'b1, 1'b1, 16'd400, 16'd30, 16'd400);
        set_config(24'h010000, 8'd0, 1'b0, 1'b0);
        send_status(1'b1, 1'b1, 1'b1, 1'b1, 16'd500, 16'd40, 16'd500);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin scale = 24'hFFFFFF; itime = 8'd0;   als_en = 1'b1; prox_en = 1'b1; end
                1: begin scale = 24'h000000; itime = 8'd255; als_en = 1'b1; prox_en = 1'b1; end
                2: begin scale = 24'h010000; itime = 8'd193; als_en = 1'b1; prox_en = 1'b0; end
                3: begin scale = 24'h000001; itime = 8'd224; als_en = 1'b0; prox_en = 1'b1; end
                default: begin
                    scale = 24'($urandom_range(0, 24'hFFFFFF));
                    itime = 8'($urandom_range(0, 255));
                    als_en = ($urandom_range(0, 4) != 0);
                    prox_en = ($urandom_range(0, 4) != 0);
                end
            endcase
            set_config(scale, itime, als_en, prox_en);
            repeat (PHASE_BEATS) send_random_status();
        end
        s_valid <= 1'b0;

        while (n_pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (n_fail == 0 && n_pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/als_pkg.sv
rtl/als_seq.sv
rtl/als_dp.sv
rtl/als_lux_and_status_handler_core.sv
test/als_lux_checker.sv
test/tb.sv
